@@ rtl/assert_macros.svh @@
// Assertion macros included by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define GESW_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked out of reset
`define GESW_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/gesw_pkg.sv @@
// Types, codes and helpers of the graph edge store
package gesw_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int VTX_W        = $clog2(MAX_VERTICES);
  localparam int ROW_W        = MAX_VERTICES;
  localparam int CNT_W        = 12;
  localparam int VCNT_W       = 7;
  localparam int SLOTS        = 4;
  localparam int SLOT_W       = $clog2(SLOTS);

  localparam logic [VCNT_W-1:0] VCOUNT_RST = VCNT_W'(64);
  localparam logic [VCNT_W-1:0] VCOUNT_MAX = VCNT_W'(MAX_VERTICES);

  typedef logic [VTX_W-1:0]  vtx_t;
  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [SLOT_W-1:0] slot_t;

  typedef enum logic [2:0] {
    OP_CLEAR  = 3'd0,
    OP_ADD    = 3'd1,
    OP_REMOVE = 3'd2,
    OP_QUERY  = 3'd3,
    OP_SWAP   = 3'd4
  } opcode_t;

  typedef enum logic [2:0] {
    ST_DONE    = 3'd0,
    ST_REJECT  = 3'd1,
    ST_TARGET  = 3'd2,
    ST_PRECOND = 3'd3,
    ST_RANGE   = 3'd4
  } status_t;

  localparam logic [1:0] LVL_NONE   = 2'd0;
  localparam logic [1:0] LVL_STRICT = 2'd2;

  // One remove or add of the pair held in two row slots
  typedef struct packed {
    slot_t u_slot;
    slot_t v_slot;
    logic  add;
  } step_req_t;

  function automatic logic vtx_in_range(vtx_t v, logic [VCNT_W-1:0] vcount);
    logic [VCNT_W-1:0] lim;
    lim = (vcount < VCOUNT_MAX) ? vcount : VCOUNT_MAX;
    return {{(VCNT_W-VTX_W){1'b0}}, v} < lim;
  endfunction

endpackage

@@ rtl/gesw_row_ram.sv @@
// Adjacency row memory with registered read and per-row valid bits
module gesw_row_ram import gesw_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic clr,
  input  logic wr_en,
  input  vtx_t wr_addr,
  input  row_t wr_data,
  input  vtx_t rd_addr,
  output row_t rd_data
);

  row_t mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] vld_r;
  row_t rd_q_r;
  logic rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= vld_r[rd_addr];
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

@@ rtl/gesw_step.sv @@
// Single add or remove applied to the four buffered rows
module gesw_step import gesw_pkg::*; (
  input  vtx_t      idx      [SLOTS],
  input  row_t      rows     [SLOTS],
  input  step_req_t req,
  output row_t      rows_nxt [SLOTS],
  output logic      changed
);

  vtx_t u;
  vtx_t v;
  logic present;

  assign u       = idx[req.u_slot];
  assign v       = idx[req.v_slot];
  assign present = rows[req.u_slot][v];
  assign changed = (u != v) && (req.add ? !present : present);

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      rows_nxt[i] = rows[i];
      if (changed && idx[i] == u) begin
        rows_nxt[i][v] = req.add;
      end
      if (changed && idx[i] == v) begin
        rows_nxt[i][u] = req.add;
      end
    end
  end

endmodule

@@ rtl/graph_edge_store_with_swap_top.sv @@
// Top level of the graph edge store with double edge swap
//
// Keeps a simple undirected graph of up to 64 vertices as a symmetric
// adjacency bit matrix in one row memory, plus a half-edge counter.
// Input words (in_valid/in_ready) carry an opcode, four vertices and a
// swap test level; every input word yields exactly one result word
// (out_valid/out_ready) with status, edge_present and half_edge_count.
// cfg_wr_en/cfg_wr_data set the number of vertices in use; write it only
// while the block is idle.
// Clear, bad opcode and out-of-range words go straight to the result.
// Other words use the single row memory port in turn: four rows are
// read one per cycle; a query, or a swap that fails its checks, then
// gives its result; otherwise the rows are worked on one step per cycle,
// then written back one per cycle.
// One word is in work at a time; a new word is taken while the previous
// result still waits in the output register. If the receiver stalls, the
// finished result holds in the output stage and the block stops before
// its next result. Reset empties the graph (per-row valid bits clear at
// once), zeroes the counter and sets the vertex count to 64.
module graph_edge_store_with_swap_top import gesw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        in_opcode,
  input  logic [VTX_W-1:0]  in_vertex_a,
  input  logic [VTX_W-1:0]  in_vertex_b,
  input  logic [VTX_W-1:0]  in_vertex_c,
  input  logic [VTX_W-1:0]  in_vertex_d,
  input  logic [1:0]        in_test_level,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_status,
  output logic              out_edge_present,
  output logic [CNT_W-1:0]  out_half_edge_count,
  input  logic              cfg_wr_en,
  input  logic [VCNT_W-1:0] cfg_wr_data
);

  `include "assert_macros.svh"

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CAPT,
    S_EVAL,
    S_STEP,
    S_WB,
    S_DONE
  } state_t;

  state_t            state_r;
  logic [VCNT_W-1:0] vcount_r;
  vtx_t              idx_r   [SLOTS];
  row_t              rows_r  [SLOTS];
  row_t              rows_stp[SLOTS];
  slot_t             cnt_r;
  slot_t             last_r;
  logic [2:0]        op_r;
  logic [1:0]        level_r;
  status_t           status_r;
  logic              present_r;
  logic [CNT_W-1:0]  half_r;
  logic              out_valid_r;
  logic [2:0]        out_status_r;
  logic              out_present_r;
  logic [CNT_W-1:0]  out_half_r;

  logic      accept;
  logic      ram_clr;
  logic      ram_we;
  vtx_t      ram_addr;
  row_t      ram_rdata;
  step_req_t req;
  logic      stp_chg;
  logic      ab_ok;
  logic      cd_ok;
  logic      isolated;
  logic      target_hit;
  logic      distinct;
  logic      sources_ok;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign ab_ok    = vtx_in_range(in_vertex_a, vcount_r) && vtx_in_range(in_vertex_b, vcount_r);
  assign cd_ok    = vtx_in_range(in_vertex_c, vcount_r) && vtx_in_range(in_vertex_d, vcount_r);
  assign ram_clr  = accept && (in_opcode == OP_CLEAR);
  assign ram_we   = (state_r == S_WB);
  assign ram_addr = idx_r[cnt_r];

  // swap order: remove a-b, remove c-d, add a-c, add b-d
  always_comb begin
    req.add = (op_r == OP_SWAP) ? cnt_r[1] : (op_r == OP_ADD);
    case (cnt_r)
      2'd0:    begin req.u_slot = 2'd0; req.v_slot = 2'd1; end
      2'd1:    begin req.u_slot = 2'd2; req.v_slot = 2'd3; end
      2'd2:    begin req.u_slot = 2'd0; req.v_slot = 2'd2; end
      default: begin req.u_slot = 2'd1; req.v_slot = 2'd3; end
    endcase
  end

  assign isolated   = (rows_r[0] == '0) || (rows_r[1] == '0) ||
                      (rows_r[2] == '0) || (rows_r[3] == '0);
  assign target_hit = rows_r[0][idx_r[2]] || rows_r[1][idx_r[3]];
  assign distinct   = (idx_r[0] != idx_r[1]) && (idx_r[0] != idx_r[2]) &&
                      (idx_r[0] != idx_r[3]) && (idx_r[1] != idx_r[2]) &&
                      (idx_r[1] != idx_r[3]) && (idx_r[2] != idx_r[3]);
  assign sources_ok = rows_r[0][idx_r[1]] && rows_r[2][idx_r[3]];

  gesw_row_ram u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (ram_clr),
    .wr_en   (ram_we),
    .wr_addr (ram_addr),
    .wr_data (rows_r[cnt_r]),
    .rd_addr (ram_addr),
    .rd_data (ram_rdata)
  );

  gesw_step u_step (
    .idx      (idx_r),
    .rows     (rows_r),
    .req      (req),
    .rows_nxt (rows_stp),
    .changed  (stp_chg)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vcount_r    <= VCOUNT_RST;
      half_r      <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (cfg_wr_en) begin
        vcount_r <= cfg_wr_data;
      end
      if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            op_r      <= in_opcode;
            level_r   <= in_test_level;
            idx_r[0]  <= in_vertex_a;
            idx_r[1]  <= in_vertex_b;
            idx_r[2]  <= in_vertex_c;
            idx_r[3]  <= in_vertex_d;
            present_r <= 1'b0;
            cnt_r     <= '0;
            if (in_opcode == OP_CLEAR) begin
              half_r   <= '0;
              status_r <= ST_DONE;
              state_r  <= S_DONE;
            end else if (in_opcode > OP_SWAP || !ab_ok ||
                         (in_opcode == OP_SWAP && !cd_ok)) begin
              status_r <= ST_RANGE;
              state_r  <= S_DONE;
            end else begin
              state_r <= S_READ;
            end
          end
        end
        S_READ: begin
          if (cnt_r != '0) begin
            rows_r[cnt_r - 2'd1] <= ram_rdata;
          end
          cnt_r <= cnt_r + 2'd1;
          if (cnt_r == 2'd3) begin
            state_r <= S_CAPT;
          end
        end
        S_CAPT: begin
          rows_r[3] <= ram_rdata;
          cnt_r     <= '0;
          state_r   <= S_EVAL;
        end
        S_EVAL: begin
          present_r <= rows_r[0][idx_r[1]];
          last_r    <= '0;
          status_r  <= ST_DONE;
          state_r   <= S_STEP;
          if (op_r == OP_QUERY) begin
            status_r <= rows_r[0][idx_r[1]] ? ST_DONE : ST_REJECT;
            state_r  <= S_DONE;
          end else if (op_r == OP_SWAP) begin
            last_r <= 2'd3;
            if (isolated) begin
              status_r <= ST_PRECOND;
              state_r  <= S_DONE;
            end else if (level_r != LVL_NONE && target_hit) begin
              status_r <= ST_TARGET;
              state_r  <= S_DONE;
            end else if (level_r == LVL_STRICT && !(distinct && sources_ok)) begin
              status_r <= ST_PRECOND;
              state_r  <= S_DONE;
            end
          end
        end
        S_STEP: begin
          rows_r <= rows_stp;
          if (stp_chg) begin
            half_r <= req.add ? half_r + CNT_W'(2) : half_r - CNT_W'(2);
          end
          if (op_r != OP_SWAP) begin
            status_r <= stp_chg ? ST_DONE : ST_REJECT;
          end
          cnt_r <= cnt_r + 2'd1;
          if (cnt_r == last_r) begin
            cnt_r   <= '0;
            state_r <= S_WB;
          end
        end
        S_WB: begin
          cnt_r <= cnt_r + 2'd1;
          if (cnt_r == 2'd3) begin
            present_r <= rows_r[0][idx_r[1]];
            state_r   <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r   <= 1'b1;
            out_status_r  <= status_r;
            out_present_r <= present_r;
            out_half_r    <= half_r;
            state_r       <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_edge_present    = out_present_r;
  assign out_half_edge_count = out_half_r;

  `GESW_ASSERT_IMP(a_half_even, out_valid, !out_half_edge_count[0])
  `GESW_ASSERT_IMP(a_range_absent, out_valid && out_status == ST_RANGE, !out_edge_present)
  `GESW_ASSERT_NXT(a_one_in_work, accept, !in_ready)
  `GESW_ASSERT_IMP(a_no_write_idle, state_r == S_IDLE, !ram_we)

endmodule

@@ test/graph_result_checker.sv @@
// Checker of the graph edge store: predicts each result word and compares it
module graph_result_checker import gesw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [2:0]        in_opcode,
  input  vtx_t              in_vertex_a,
  input  vtx_t              in_vertex_b,
  input  vtx_t              in_vertex_c,
  input  vtx_t              in_vertex_d,
  input  logic [1:0]        in_test_level,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [2:0]        out_status,
  input  logic              out_edge_present,
  input  logic [CNT_W-1:0]  out_half_edge_count,
  input  logic              cfg_wr_en,
  input  logic [VCNT_W-1:0] cfg_wr_data,
  output int                fail_count,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_t          status;
    logic             present;
    logic [CNT_W-1:0] half_cnt;
  } graph_result_t;

  row_t              adjacency [MAX_VERTICES];
  int unsigned       half_edge_total;
  logic [VCNT_W-1:0] vertex_limit;
  graph_result_t     awaited_results [$];

  function automatic bit vertex_usable(vtx_t v);
    logic [VCNT_W-1:0] lim;
    lim = (vertex_limit < VCOUNT_MAX) ? vertex_limit : VCOUNT_MAX;
    return VCNT_W'(v) < lim;
  endfunction

  function automatic bit link_pair(vtx_t u, vtx_t v);
    if (u == v || adjacency[u][v]) return 1'b0;
    adjacency[u][v] = 1'b1;
    adjacency[v][u] = 1'b1;
    half_edge_total += 2;
    return 1'b1;
  endfunction

  function automatic bit unlink_pair(vtx_t u, vtx_t v);
    if (u == v || !adjacency[u][v]) return 1'b0;
    adjacency[u][v] = 1'b0;
    adjacency[v][u] = 1'b0;
    half_edge_total -= 2;
    return 1'b1;
  endfunction

  function automatic status_t swap_pairs(vtx_t a, vtx_t b, vtx_t c, vtx_t d,
                                         logic [1:0] level);
    bit distinct;
    if (adjacency[a] == '0 || adjacency[b] == '0 || adjacency[c] == '0 ||
        adjacency[d] == '0) return ST_PRECOND;
    if (level != LVL_NONE && (adjacency[a][c] || adjacency[b][d])) return ST_TARGET;
    if (level == LVL_STRICT) begin
      distinct = a != b && a != c && a != d && b != c && b != d && c != d;
      if (!distinct || !adjacency[a][b] || !adjacency[c][d]) return ST_PRECOND;
    end
    void'(unlink_pair(a, b));
    void'(unlink_pair(c, d));
    void'(link_pair(a, c));
    void'(link_pair(b, d));
    return ST_DONE;
  endfunction

  function automatic graph_result_t apply_graph_command(logic [2:0] op, vtx_t a, vtx_t b,
                                                        vtx_t c, vtx_t d, logic [1:0] level);
    graph_result_t r;
    r.status  = ST_DONE;
    r.present = 1'b0;
    if (op == OP_CLEAR) begin
      foreach (adjacency[i]) adjacency[i] = '0;
      half_edge_total = 0;
    end else if (op > OP_SWAP) begin
      r.status = ST_RANGE;
    end else if (!vertex_usable(a) || !vertex_usable(b) ||
                 (op == OP_SWAP && (!vertex_usable(c) || !vertex_usable(d)))) begin
      r.status = ST_RANGE;
    end else begin
      case (op)
        OP_ADD:    r.status = link_pair(a, b) ? ST_DONE : ST_REJECT;
        OP_REMOVE: r.status = unlink_pair(a, b) ? ST_DONE : ST_REJECT;
        OP_QUERY:  r.status = adjacency[a][b] ? ST_DONE : ST_REJECT;
        default:   r.status = swap_pairs(a, b, c, d, level);
      endcase
      r.present = adjacency[a][b];
    end
    r.half_cnt = half_edge_total[CNT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("checker: %s", what);
    fail_count++;
  endtask

  always @(posedge clk) begin
    graph_result_t want;
    if (!rst_n) begin
      foreach (adjacency[i]) adjacency[i] = '0;
      half_edge_total = 0;
      vertex_limit    = VCOUNT_RST;
      awaited_results.delete();
      pending <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("result word with no command waiting");
        end else begin
          want = awaited_results.pop_front();
          if (out_status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", out_status, want.status));
          if (out_edge_present !== want.present)
            report_mismatch($sformatf("edge_present got %0d want %0d",
                                      out_edge_present, want.present));
          if (out_half_edge_count !== want.half_cnt)
            report_mismatch($sformatf("half_edge_count got %0d want %0d",
                                      out_half_edge_count, want.half_cnt));
        end
      end
      if (in_valid && in_ready)
        awaited_results.push_back(apply_graph_command(in_opcode, in_vertex_a, in_vertex_b,
                                                      in_vertex_c, in_vertex_d,
                                                      in_test_level));
      if (cfg_wr_en) vertex_limit = cfg_wr_data;
      pending <= awaited_results.size();
    end
  end

endmodule

@@ test/tb.sv @@
// Testbench top of the graph edge store: drives commands, configuration and verdict
module tb;
  import gesw_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;
  localparam logic [1:0] LVL_TARGETS  = 2'd1;
  localparam logic [1:0] LVL_ALIAS    = 2'd3;
  localparam int         STALL_LIMIT  = 3000;
  localparam int         PHASES       = 9;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [2:0]        in_opcode;
  vtx_t              in_vertex_a;
  vtx_t              in_vertex_b;
  vtx_t              in_vertex_c;
  vtx_t              in_vertex_d;
  logic [1:0]        in_test_level;
  logic              out_valid;
  logic              out_ready;
  logic [2:0]        out_status;
  logic              out_edge_present;
  logic [CNT_W-1:0]  out_half_edge_count;
  logic              cfg_wr_en;
  logic [VCNT_W-1:0] cfg_wr_data;
  int                fail_count;
  int                pending;
  int                send_idle_pct;
  int                recv_stall_pct;
  int                quiet_cycles;

  int phase_vcount [PHASES] = '{8, 64, 5, 127, 1, 16, 0, 4, 64};
  int phase_items  [PHASES] = '{90, 90, 90, 90, 30, 90, 30, 90, 90};
  int mode_send    [4]      = '{0, 51, 0, 29};
  int mode_recv    [4]      = '{0, 0, 51, 29};

  graph_edge_store_with_swap_top u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_opcode           (in_opcode),
    .in_vertex_a         (in_vertex_a),
    .in_vertex_b         (in_vertex_b),
    .in_vertex_c         (in_vertex_c),
    .in_vertex_d         (in_vertex_d),
    .in_test_level       (in_test_level),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_edge_present    (out_edge_present),
    .out_half_edge_count (out_half_edge_count),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data)
  );

  graph_result_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_opcode           (in_opcode),
    .in_vertex_a         (in_vertex_a),
    .in_vertex_b         (in_vertex_b),
    .in_vertex_c         (in_vertex_c),
    .in_vertex_d         (in_vertex_d),
    .in_test_level       (in_test_level),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_edge_present    (out_edge_present),
    .out_half_edge_count (out_half_edge_count),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .fail_count          (fail_count),
    .pending             (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(input logic [2:0] op, input vtx_t a, input vtx_t b,
                           input vtx_t c, input vtx_t d, input logic [1:0] level);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_vertex_a   <= a;
    in_vertex_b   <= b;
    in_vertex_c   <= c;
    in_vertex_d   <= d;
    in_test_level <= level;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_vertex_count(input int value);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= VCNT_W'(value);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  function automatic vtx_t pick_vertex(input int lim);
    int span;
    span = (lim > 8) ? 8 : lim;
    if (span == 0 || $urandom_range(99) < 12) return vtx_t'($urandom_range(63));
    if (lim > span && $urandom_range(99) < 15) return vtx_t'($urandom_range(lim - 1));
    return vtx_t'($urandom_range(span - 1));
  endfunction

  task automatic send_random(input int lim);
    int         roll;
    logic [2:0] op;
    logic [1:0] level;
    roll = $urandom_range(99);
    if (roll < 2) op = OP_CLEAR;
    else if (roll < 37) op = OP_ADD;
    else if (roll < 52) op = OP_REMOVE;
    else if (roll < 67) op = OP_QUERY;
    else if (roll < 97) op = OP_SWAP;
    else op = OP_UNUSED_LO + 3'($urandom_range(2));
    level = ($urandom_range(9) < 5) ? LVL_STRICT : 2'($urandom_range(3));
    send_word(op, pick_vertex(lim), pick_vertex(lim), pick_vertex(lim), pick_vertex(lim),
              level);
  endtask

  initial begin
    int lim;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_opcode      = OP_CLEAR;
    in_vertex_a    = '0;
    in_vertex_b    = '0;
    in_vertex_c    = '0;
    in_vertex_d    = '0;
    in_test_level  = LVL_NONE;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(OP_QUERY, 6'd0, 6'd63, 6'd0, 6'd0, LVL_NONE);
    send_word(OP_ADD, 6'd0, 6'd63, 6'd63, 6'd63, LVL_ALIAS);
    send_word(OP_ADD, 6'd63, 6'd0, 6'd0, 6'd0, LVL_NONE);
    send_word(OP_ADD, 6'd5, 6'd5, 6'd0, 6'd0, LVL_NONE);
    send_word(OP_QUERY, 6'd63, 6'd0, 6'd0, 6'd0, LVL_NONE);
    send_word(OP_REMOVE, 6'd1, 6'd2, 6'd0, 6'd0, LVL_NONE);
    send_word(OP_REMOVE, 6'd0, 6'd63, 6'd0, 6'd0, LVL_NONE);
    send_word(OP_UNUSED_LO, 6'd1, 6'd2, 6'd3, 6'd4, LVL_NONE);
    send_word(OP_UNUSED_HI, 6'd63, 6'd63, 6'd63, 6'd63, LVL_ALIAS);
    send_word(OP_ADD, 6'd0, 6'd1, 6'd0, 6'd0, LVL_NONE);
    send_word(OP_ADD, 6'd2, 6'd3, 6'd0, 6'd0, LVL_NONE);
    send_word(OP_SWAP, 6'd0, 6'd1, 6'd2, 6'd3, LVL_STRICT);
    send_word(OP_SWAP, 6'd0, 6'd2, 6'd4, 6'd1, LVL_NONE);
    send_word(OP_SWAP, 6'd0, 6'd3, 6'd2, 6'd1, LVL_TARGETS);
    send_word(OP_SWAP, 6'd0, 6'd3, 6'd2, 6'd1, LVL_ALIAS);
    send_word(OP_SWAP, 6'd0, 6'd3, 6'd2, 6'd1, LVL_STRICT);
    send_word(OP_SWAP, 6'd0, 6'd2, 6'd0, 6'd2, LVL_STRICT);
    send_word(OP_SWAP, 6'd0, 6'd1, 6'd3, 6'd2, LVL_STRICT);
    send_word(OP_SWAP, 6'd0, 6'd2, 6'd1, 6'd3, LVL_NONE);
    send_word(OP_SWAP, 6'd0, 6'd1, 6'd0, 6'd1, LVL_NONE);
    write_vertex_count(4);
    send_word(OP_ADD, 6'd0, 6'd4, 6'd0, 6'd0, LVL_NONE);
    send_word(OP_SWAP, 6'd2, 6'd3, 6'd0, 6'd63, LVL_NONE);
    send_word(OP_ADD, 6'd3, 6'd2, 6'd0, 6'd0, LVL_NONE);
    send_word(OP_CLEAR, 6'd63, 6'd63, 6'd63, 6'd63, LVL_ALIAS);

    for (int p = 0; p < PHASES; p++) begin
      write_vertex_count(phase_vcount[p]);
      lim = (phase_vcount[p] < MAX_VERTICES) ? phase_vcount[p] : MAX_VERTICES;
      send_idle_pct  = mode_send[p % 4];
      recv_stall_pct = mode_recv[p % 4];
      repeat (phase_items[p]) send_random(lim);
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/gesw_pkg.sv
rtl/gesw_row_ram.sv
rtl/gesw_step.sv
rtl/graph_edge_store_with_swap_top.sv
test/graph_result_checker.sv
test/tb.sv
